FILE: src/mac_address_set_table_assert.svh
// ----------------------------------------------------------------------------
// MAC address set table assertion macros
// Shorthand for the clocked, reset-qualified checks used by the table.
// ----------------------------------------------------------------------------
`ifndef MAC_ADDRESS_SET_TABLE_ASSERT_SVH
`define MAC_ADDRESS_SET_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mast check failed");

// The consequent must hold in the cycle after the antecedent.
`define MAST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mast check failed");

`endif

FILE: src/mast_pkg.sv
// ----------------------------------------------------------------------------
// MAC address set table package
// Request codes, field widths and the default table size.
// ----------------------------------------------------------------------------
package mast_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int MAC_W          = 48;
    localparam int REQ_W          = 2;
    localparam int ENTRY_TOTAL_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_type_t;

endpackage

FILE: src/mac_address_set_table.sv
// ----------------------------------------------------------------------------
// MAC address set table
// Holds up to CAPACITY distinct 48-bit addresses and serves lookup, insert,
// remove and clear requests; all but clear scan the slots one per cycle.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   req_type, mac_addr
//  out      output     out_valid / out_stall hit, status, entry_total
//
//  A lookup, insert or remove stalls the input until it is done: one slot of
//  the address memory is read per cycle in S_SCAN, then S_DRAIN drains the
//  compare stage and S_APPLY writes back. A clear goes straight to S_APPLY.
//  The result word sits in an output register, so the next request is taken
//  while an earlier result waits; write-back waits only if that register is
//  still full. Reset empties the table at once through the valid flip-flops.
// ----------------------------------------------------------------------------
`include "mac_address_set_table_assert.svh"

module mac_address_set_table #(
    parameter int CAPACITY = mast_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mast_pkg::REQ_W-1:0]         req_type,
    input  logic [mast_pkg::MAC_W-1:0]         mac_addr,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic                               status,
    output logic [mast_pkg::ENTRY_TOTAL_W-1:0] entry_total
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CNT_W > mast_pkg::ENTRY_TOTAL_W) ? CNT_W
                                                              : mast_pkg::ENTRY_TOTAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY
    } state_t;

    state_t                             state_reg, state_next;
    logic [mast_pkg::REQ_W-1:0]         req_reg, req_next;
    logic [mast_pkg::MAC_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic                               cmp_en_reg, cmp_en_next;
    logic [IDX_W-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic                               found_reg, found_next;
    logic [IDX_W-1:0]                   found_idx_reg, found_idx_next;
    logic                               free_found_reg, free_found_next;
    logic [IDX_W-1:0]                   free_idx_reg, free_idx_next;
    logic [CAPACITY-1:0]                slot_valid_reg, slot_valid_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               hit_reg, hit_next;
    logic                               status_reg, status_next;
    logic [mast_pkg::ENTRY_TOTAL_W-1:0] total_reg, total_next;
    logic [EXT_W-1:0]                   count_ext;
    logic                               mem_wr_en;

    // Address storage; only entries with a set valid bit are ever compared.
    logic [mast_pkg::MAC_W-1:0]         slot_addr_mem [CAPACITY];
    logic [mast_pkg::MAC_W-1:0]         rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_addr_mem[free_idx_reg] <= addr_reg;
        end
        rd_data_reg <= slot_addr_mem[idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        cmp_en_next     = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_valid_next = slot_valid_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg & out_stall;
        hit_next        = hit_reg;
        status_next     = status_reg;
        total_next      = total_reg;
        count_ext       = '0;
        mem_wr_en       = 1'b0;

        // Compare stage works on the word read in the previous cycle.
        if (cmp_en_reg && slot_valid_reg[cmp_idx_reg] && (rd_data_reg == addr_reg))
        begin
            found_next     = 1'b1;
            found_idx_next = cmp_idx_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    addr_next       = mac_addr;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = (req_type == mast_pkg::REQ_CLEAR) ? S_APPLY : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmp_en_next  = 1'b1;
                cmp_idx_next = idx_reg;
                if (!free_found_reg && !slot_valid_reg[idx_reg])
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    hit_next    = 1'b0;
                    status_next = 1'b0;
                    unique case (req_reg)
                        mast_pkg::REQ_CLEAR:
                        begin
                            slot_valid_next = '0;
                            count_next      = '0;
                        end
                        mast_pkg::REQ_INSERT:
                        begin
                            hit_next = found_reg;
                            if (!found_reg)
                            begin
                                if (free_found_reg)
                                begin
                                    slot_valid_next[free_idx_reg] = 1'b1;
                                    count_next                    = count_reg + CNT_W'(1);
                                    mem_wr_en                     = 1'b1;
                                end
                                else
                                begin
                                    status_next = 1'b1;
                                end
                            end
                        end
                        mast_pkg::REQ_REMOVE:
                        begin
                            hit_next = found_reg;
                            if (found_reg)
                            begin
                                slot_valid_next[found_idx_reg] = 1'b0;
                                count_next                     = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            hit_next = found_reg;
                        end
                    endcase
                    count_ext      = EXT_W'(count_next);
                    total_next     = count_ext[mast_pkg::ENTRY_TOTAL_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmp_en_reg     <= 1'b0;
            slot_valid_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            status_reg     <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_en_reg     <= cmp_en_next;
            slot_valid_reg <= slot_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            hit_reg        <= hit_next;
            status_reg     <= status_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;

    `MAST_ASSERT_SAME(a_count_matches_valid, 1'b1,
        count_reg == CNT_W'($countones(slot_valid_reg)))
    `MAST_ASSERT_SAME(a_full_drop_no_hit, out_valid_reg && status_reg, !hit_reg)
    `MAST_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != S_IDLE)
    `MAST_ASSERT_NEXT(a_result_after_apply,
        (state_reg == S_APPLY) && (!out_valid_reg || !out_stall),
        out_valid_reg && (state_reg == S_IDLE))

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC address set table testbench
// Drives lookup, insert, remove and clear words into the table through the
// valid/stall channel and checks every result word against a slot-level
// predictor of the set. It covers directed corner cases, a full table,
// long output back-pressure and a long run of random traffic with random
// gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_SLOTS = mast_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        logic                               hit;
        logic                               status;
        logic [mast_pkg::ENTRY_TOTAL_W-1:0] entry_total;
    } table_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [mast_pkg::REQ_W-1:0]         req_type = '0;
    logic [mast_pkg::MAC_W-1:0]         mac_addr = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               hit;
    logic                               status;
    logic [mast_pkg::ENTRY_TOTAL_W-1:0] entry_total;

    // Predicted contents of the table.
    logic [mast_pkg::MAC_W-1:0] slot_mac [TABLE_SLOTS];
    bit                         slot_used [TABLE_SLOTS];
    int                         stored_total = 0;

    table_result_t              pending_results [$];
    logic [mast_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];

    int error_count = 0;
    int lookup_count = 0;
    int insert_count = 0;
    int remove_count = 0;
    int clear_count = 0;
    int hit_count = 0;
    int full_drop_count = 0;
    int result_count = 0;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int hold_request = 0;

    mac_address_set_table #(
        .CAPACITY   (TABLE_SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .mac_addr   (mac_addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .status     (status),
        .entry_total(entry_total)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mast_pkg::MAC_W-1:0] random_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[mast_pkg::MAC_W-1:0];
    endfunction

    // Applies one request to the predicted set and returns the result word.
    function automatic table_result_t apply_request(mast_pkg::req_type_t kind,
                                                    logic [mast_pkg::MAC_W-1:0] addr);
        table_result_t res;
        int            found;
        int            free_idx;
        res = '0;
        found = -1;
        free_idx = -1;
        if (kind == mast_pkg::REQ_CLEAR)
        begin
            clear_count++;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            stored_total = 0;
        end
        else
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                if (found < 0 && slot_used[i] && slot_mac[i] == addr)
                    found = i;
                if (free_idx < 0 && !slot_used[i])
                    free_idx = i;
            end
            res.hit = (found >= 0);
            if (res.hit)
                hit_count++;
            case (kind)
                mast_pkg::REQ_LOOKUP: lookup_count++;
                mast_pkg::REQ_INSERT:
                begin
                    insert_count++;
                    if (found < 0)
                    begin
                        if (free_idx < 0)
                        begin
                            res.status = 1'b1;
                            full_drop_count++;
                        end
                        else
                        begin
                            slot_mac[free_idx] = addr;
                            slot_used[free_idx] = 1'b1;
                            stored_total++;
                        end
                    end
                end
                mast_pkg::REQ_REMOVE:
                begin
                    remove_count++;
                    if (found >= 0)
                    begin
                        slot_used[found] = 1'b0;
                        stored_total--;
                    end
                end
                default: ;
            endcase
        end
        res.entry_total = mast_pkg::ENTRY_TOTAL_W'(stored_total);
        return res;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid stays
    // high afterwards so that back-to-back words need no extra cycle.
    task automatic send_request(mast_pkg::req_type_t kind, logic [mast_pkg::MAC_W-1:0] addr);
        in_valid <= 1'b1;
        req_type <= kind;
        mac_addr <= addr;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(), apply_request(kind, addr));
    endtask

    task automatic sender_gap();
        int n;
        n = tx_quiet ? 0 : pick_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result receiver: random stalls, plus a long hold when a test asks.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
                out_stall <= 1'b0;
            else if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = rx_quiet ? 0 : pick_gap();
            end
        end
    end

    // Compares each delivered result word with the oldest prediction.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result word with no request waiting");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (entry_total !== want.entry_total)
                begin
                    $error("entry_total: expected %0d, actual %0d",
                           want.entry_total, entry_total);
                    error_count++;
                end
            end
        end
    end

    task automatic test_basic_requests();
        send_request(mast_pkg::REQ_LOOKUP, 48'h0);
        send_request(mast_pkg::REQ_INSERT, 48'h0);
        send_request(mast_pkg::REQ_INSERT, 48'hFFFF_FFFF_FFFF);
        send_request(mast_pkg::REQ_INSERT, 48'h0);
        send_request(mast_pkg::REQ_REMOVE, 48'hA5A5_5A5A_A5A5);
        send_request(mast_pkg::REQ_REMOVE, 48'h0);
        send_request(mast_pkg::REQ_LOOKUP, 48'h0);
        // The address of a clear carries no meaning.
        send_request(mast_pkg::REQ_CLEAR, 48'hFFFF_FFFF_FFFF);
        send_request(mast_pkg::REQ_LOOKUP, 48'hFFFF_FFFF_FFFF);
        wait_all_results();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            send_request(mast_pkg::REQ_INSERT, 48'h1 << (3 * i));
            sender_gap();
        end
        send_request(mast_pkg::REQ_INSERT, 48'h5555_AAAA_5555);
        send_request(mast_pkg::REQ_INSERT, 48'h1);
        send_request(mast_pkg::REQ_CLEAR, 48'h0);
        wait_all_results();
    endtask

    // The receiver holds off for a long time while words keep coming, so the
    // table fills its result register and then stalls its input.
    task automatic test_output_backpressure();
        tx_quiet = 1'b1;
        hold_request = 300;
        for (int i = 0; i < 8; i++)
        begin
            if (i % 2 == 1)
                send_request(mast_pkg::REQ_LOOKUP, random_mac());
            else
                send_request(mast_pkg::REQ_INSERT, random_mac());
        end
        wait_all_results();
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_traffic(int rounds);
        int                         insert_pct;
        int                         remove_pct;
        int                         r;
        mast_pkg::req_type_t        kind;
        logic [mast_pkg::MAC_W-1:0] addr;
        for (int i = 0; i < POOL_SIZE; i++)
            mac_pool[i] = random_mac();
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int round = 0; round < rounds; round++)
        begin
            // Each round leans differently, so the table both fills and empties.
            insert_pct = $urandom_range(20, 60);
            remove_pct = (98 - insert_pct) / 2;
            tx_quiet = (round % 4 == 3);
            rx_quiet = (round % 4 == 3);
            for (int n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    kind = mast_pkg::REQ_CLEAR;
                else if (r < 2 + insert_pct)
                    kind = mast_pkg::REQ_INSERT;
                else if (r < 2 + insert_pct + remove_pct)
                    kind = mast_pkg::REQ_REMOVE;
                else
                    kind = mast_pkg::REQ_LOOKUP;
                if ($urandom_range(0, 99) < 85)
                    addr = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    addr = random_mac();
                send_request(kind, addr);
                sender_gap();
            end
            if (round % 3 == 2)
                wait_all_results();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_mac[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_requests();
        test_full_table();
        test_output_backpressure();
        test_random_traffic(10);

        wait_all_results();
        repeat (2 * TABLE_SLOTS + 8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end

        $display("Ran %0d requests (%0d lookups, %0d inserts, %0d removes, %0d clears).",
                 lookup_count + insert_count + remove_count + clear_count,
                 lookup_count, insert_count, remove_count, clear_count);
        $display("Saw %0d result words, %0d hits, %0d inserts refused by a full table.",
                 result_count, hit_count, full_drop_count);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Timeout with %0d result words outstanding.", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mast_pkg.sv
src/mac_address_set_table.sv
dv/testbench.sv
